/* hdl/ght_pkg.sv */
package ght_pkg;

   localparam int CAPACITY   = 64;
   localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SIZE_W     = 7;
   localparam int SIZE_LIMIT = (CAPACITY < 64) ? CAPACITY : 64;
   localparam int WORD_W     = 32;
   localparam int HANDLE_W   = 64;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int ENTRY_W    = 3 * WORD_W;

   // The free-slot search works on groups of eight slots.
   localparam int GROUP  = 8;
   localparam int BIT_W  = $clog2(GROUP);
   localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;
   localparam int GRP_W  = (NGROUP > 1) ? $clog2(NGROUP) : 1;

   localparam logic [WORD_W-1:0] GEN_INIT = WORD_W'(1);
   localparam logic [WORD_W-1:0] GEN_MAX  = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_OPEN      = 2'd0,
      FUNC_LOOKUP    = 2'd1,
      FUNC_CLOSE     = 2'd2,
      FUNC_CLOSE_ALL = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BADARG    = 3'd1,
      ST_BADHANDLE = 3'd2,
      ST_DENIED    = 3'd3,
      ST_FULL      = 3'd4,
      ST_TERM      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FIND,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } first_type;

   typedef struct packed {
      logic [WORD_W-1:0] gen;
      logic [WORD_W-1:0] obj;
      logic [WORD_W-1:0] acc;
   } entry_type;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle_out;
      logic [WORD_W-1:0]   object_out;
      logic [WORD_W-1:0]   granted_out;
      logic                object_valid;
      logic [SIZE_W-1:0]   active_out;
      logic                last;
   } result_type;

   // Lowest set bit: first the lowest nonempty group, then the lowest bit in it.
   function automatic first_type first_set(input logic [CAPACITY-1:0] vec);
      logic [NGROUP*GROUP-1:0] pad;
      logic [GROUP-1:0]        bits;
      logic [GRP_W-1:0]        gsel;
      logic [BIT_W-1:0]        bsel;
      first_type               res;
      pad = '0;
      pad[CAPACITY-1:0] = vec;
      gsel = '0;
      bsel = '0;
      for (int g = NGROUP - 1; g >= 0; g--) begin
         if (|pad[g*GROUP +: GROUP]) begin
            gsel = GRP_W'(g);
         end
      end
      bits = pad[gsel*GROUP +: GROUP];
      for (int b = GROUP - 1; b >= 0; b--) begin
         if (bits[b]) begin
            bsel = BIT_W'(b);
         end
      end
      res.found = |vec;
      res.idx   = SLOT_W'(32'(gsel) * GROUP + 32'(bsel));
      return res;
   endfunction

endpackage

/* hdl/ght_if.sv */
interface ght_req_if;
   import ght_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [HANDLE_W-1:0] handle;
   logic [WORD_W-1:0]   object_id;
   logic [WORD_W-1:0]   access_mask;

   modport source (output valid, func, handle, object_id, access_mask, input ready);
   modport sink (input valid, func, handle, object_id, access_mask, output ready);
endinterface

interface ght_rsp_if;
   import ght_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] handle_out;
   logic [WORD_W-1:0]   object_out;
   logic [WORD_W-1:0]   granted_out;
   logic                object_valid;
   logic [SIZE_W-1:0]   active_out;
   logic                last;

   modport source (output valid, status, handle_out, object_out, granted_out, object_valid,
                   active_out, last, input ready);
   modport sink (input valid, status, handle_out, object_out, granted_out, object_valid,
                 active_out, last, output ready);
endinterface

/* hdl/ght_ram.sv */
module ght_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/generational_handle_table.sv */
// Channel   Dir  Handshake     Payload
// req_ch    in   valid/ready   func, handle, object_id, access_mask
// rsp_ch    out  valid/ready   status, handle_out, object_out, granted_out,
//                              object_valid, active_out, last
// csr       in   csr_wr_en     csr_wr_data (table size)
//
// Open, lookup and close read the slot entry from the slot RAM in the accept cycle; the
// result is formed and written back in the execute state once the result register is free.
// Close all finds each slot in use in turn, with one RAM read and then one emit and write back
// per slot; on an empty table it gives a single result.
// Reset and a table size write clear the per-slot in-use, written and retired flags at once;
// a never-written slot reads as its reset contents, so there is no clearing pass.
// A result that waits at rsp_ch stalls the block in its execute, find or emit state until
// it is taken; the next request is still taken while the previous result waits.
module generational_handle_table (
   input  logic                     clock,
   input  logic                     reset,
   ght_req_if.sink                  req_ch,
   ght_rsp_if.source                rsp_ch,
   input  logic                     csr_wr_en,
   input  logic [ght_pkg::SIZE_W-1:0] csr_wr_data
);
   import ght_pkg::*;

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   table_size_ff;
   logic [SIZE_W-1:0]   eff_size;
   logic [CAPACITY-1:0] size_mask;
   logic [CAPACITY-1:0] in_use_ff;
   logic [CAPACITY-1:0] written_ff;
   logic [CAPACITY-1:0] retired_ff;
   logic [SIZE_W-1:0]   active_ff, active_in;
   logic                closing_ff;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   func_type            func_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [WORD_W-1:0]   obj_ff;
   logic [WORD_W-1:0]   acc_ff;
   logic                dec_ok_ff;
   logic                badarg_ff;
   logic                found_ff;

   result_type          rsp_ff, res;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_accept;
   logic                out_free;
   logic                load_rsp;
   logic                mark_open;
   logic                mark_free;
   func_type            req_func;
   logic [WORD_W-1:0]   slot_raw;
   logic [WORD_W-1:0]   slot_sub;
   logic                dec_ok;
   first_type           open_pick;
   first_type           use_pick;
   logic [CAPACITY-1:0] slot_onehot;
   logic                sweep_last;

   logic                ram_re, ram_we;
   logic [SLOT_W-1:0]   ram_raddr, ram_waddr;
   entry_type           ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           rd_entry, cur;
   logic [WORD_W-1:0]   new_gen;
   logic                match;

   // Effective size: zero acts as one, large values saturate.
   always_comb begin
      eff_size = table_size_ff;
      if (eff_size == '0) begin
         eff_size = SIZE_W'(1);
      end
      if (32'(eff_size) > SIZE_LIMIT) begin
         eff_size = SIZE_W'(SIZE_LIMIT);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         size_mask[i] = (32'(eff_size) > i);
      end
   end

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_func   = func_type'(req_ch.func);
   assign slot_raw   = req_ch.handle[WORD_W-1:0];
   assign slot_sub   = slot_raw - WORD_W'(1);
   assign dec_ok     = (slot_raw != '0) && (req_ch.handle[HANDLE_W-1:WORD_W] != '0)
                       && (slot_raw <= WORD_W'(eff_size));
   assign open_pick  = first_set(~in_use_ff & ~retired_ff & size_mask);
   assign use_pick   = first_set(in_use_ff);

   always_comb begin
      slot_onehot = '0;
      slot_onehot[slot_ff] = 1'b1;
   end
   assign sweep_last = ((in_use_ff & ~slot_onehot) == '0);

   // A slot that has not been written since initialization holds its reset contents.
   assign rd_entry = entry_type'(ram_rdata);
   always_comb begin
      if (written_ff[slot_ff]) begin
         cur = rd_entry;
      end else begin
         cur.gen = GEN_INIT;
         cur.obj = '0;
         cur.acc = '0;
      end
   end
   assign new_gen = (cur.gen == GEN_MAX) ? '0 : cur.gen + WORD_W'(1);
   assign match   = in_use_ff[slot_ff] && (cur.gen == handle_ff[HANDLE_W-1:WORD_W])
                    && (cur.obj != '0);

   ght_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_func == FUNC_CLOSE_ALL) ? S_FIND : S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_FIND: begin
            if (use_pick.found) begin
               state_in = S_EMIT;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = sweep_last ? S_IDLE : S_FIND;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs, memory access and result
   always_comb begin
      req_ch.ready = (state_ff == S_IDLE);
      ram_re       = 1'b0;
      ram_raddr    = slot_ff;
      ram_we       = 1'b0;
      ram_waddr    = slot_ff;
      ram_wdata    = '0;
      load_rsp     = 1'b0;
      mark_open    = 1'b0;
      mark_free    = 1'b0;
      res          = '0;
      res.status   = ST_OK;
      res.last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_func != FUNC_CLOSE_ALL)) begin
               ram_re    = 1'b1;
               ram_raddr = (req_func == FUNC_OPEN) ? open_pick.idx : slot_sub[SLOT_W-1:0];
            end
         end
         S_EXEC: begin
            if (out_free) begin
               load_rsp = 1'b1;
               case (func_ff)
                  FUNC_OPEN: begin
                     if (badarg_ff) begin
                        res.status = ST_BADARG;
                     end else if (closing_ff) begin
                        res.status = ST_TERM;
                     end else if (!found_ff) begin
                        res.status = ST_FULL;
                     end else begin
                        mark_open      = 1'b1;
                        res.handle_out = {cur.gen, WORD_W'(slot_ff) + WORD_W'(1)};
                     end
                  end
                  FUNC_LOOKUP: begin
                     if (!dec_ok_ff) begin
                        res.status = ST_BADHANDLE;
                     end else if (closing_ff) begin
                        res.status = ST_TERM;
                     end else if (!match) begin
                        res.status = ST_BADHANDLE;
                     end else if ((acc_ff & ~cur.acc) != '0) begin
                        res.status = ST_DENIED;
                     end else begin
                        res.object_out   = cur.obj;
                        res.granted_out  = cur.acc;
                        res.object_valid = 1'b1;
                     end
                  end
                  FUNC_CLOSE: begin
                     if (!dec_ok_ff || !match) begin
                        res.status = ST_BADHANDLE;
                     end else begin
                        mark_free        = 1'b1;
                        res.object_out   = cur.obj;
                        res.object_valid = 1'b1;
                     end
                  end
                  default: res.status = ST_OK;
               endcase
            end
         end
         S_FIND: begin
            if (use_pick.found) begin
               ram_re    = 1'b1;
               ram_raddr = use_pick.idx;
            end else if (out_free) begin
               // Close all on an empty table gives one result without an object.
               load_rsp = 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load_rsp         = 1'b1;
               mark_free        = 1'b1;
               res.object_out   = cur.obj;
               res.object_valid = 1'b1;
               res.last         = sweep_last;
            end
         end
         default: ;
      endcase
      if (mark_open) begin
         ram_we        = 1'b1;
         ram_wdata.gen = cur.gen;
         ram_wdata.obj = obj_ff;
         ram_wdata.acc = acc_ff;
      end
      if (mark_free) begin
         ram_we        = 1'b1;
         ram_wdata.gen = new_gen;
      end
      active_in = active_ff;
      if (mark_open) begin
         active_in = active_ff + SIZE_W'(1);
      end else if (mark_free && (active_ff != '0)) begin
         active_in = active_ff - SIZE_W'(1);
      end
      res.active_out = active_in;
      slot_in        = ram_re ? ram_raddr : slot_ff;
      rsp_valid_in   = load_rsp ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= SIZE_W'(64);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            table_size_ff <= csr_wr_data;
         end
      end
   end

   // A table size write reinitializes every slot.
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         in_use_ff  <= '0;
         written_ff <= '0;
         retired_ff <= '0;
         active_ff  <= '0;
         closing_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         if (mark_open) begin
            in_use_ff[slot_ff]  <= 1'b1;
            written_ff[slot_ff] <= 1'b1;
         end
         if (mark_free) begin
            in_use_ff[slot_ff]  <= 1'b0;
            written_ff[slot_ff] <= 1'b1;
            if (new_gen == '0) begin
               retired_ff[slot_ff] <= 1'b1;
            end
         end
         if (req_accept && (req_func == FUNC_CLOSE_ALL)) begin
            closing_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (req_accept) begin
         func_ff   <= req_func;
         handle_ff <= req_ch.handle;
         obj_ff    <= req_ch.object_id;
         acc_ff    <= req_ch.access_mask;
         dec_ok_ff <= dec_ok;
         badarg_ff <= (req_ch.object_id == '0) || (req_ch.access_mask == '0);
         found_ff  <= open_pick.found;
      end
      if (load_rsp) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.handle_out   = rsp_ff.handle_out;
   assign rsp_ch.object_out   = rsp_ff.object_out;
   assign rsp_ch.granted_out  = rsp_ff.granted_out;
   assign rsp_ch.object_valid = rsp_ff.object_valid;
   assign rsp_ch.active_out   = rsp_ff.active_out;
   assign rsp_ch.last         = rsp_ff.last;

`ifndef SYNTH
   a_use_not_retired: assert property (@(posedge clock) disable iff (reset)
      (in_use_ff & retired_ff) == '0)
      else $error("slot both in use and retired");

   a_active_count: assert property (@(posedge clock) disable iff (reset)
      $countones(in_use_ff) == 32'(active_ff))
      else $error("active count differs from in-use slots");

   a_use_in_size: assert property (@(posedge clock) disable iff (reset)
      (in_use_ff & ~size_mask) == '0)
      else $error("slot in use beyond table size");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (load_rsp && ((state_ff == S_EXEC) || (state_ff == S_EMIT))))
      else $error("slot write outside an emit cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset || csr_wr_en)
      req_accept |=> (state_ff != S_IDLE))
      else $error("request accepted without starting work");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ght_pkg::*;

   // Mirror of the slot table; predicts every response from the accepted requests.
   class handle_ledger;
      logic              in_use [CAPACITY];
      logic [WORD_W-1:0] generation [CAPACITY];
      logic [WORD_W-1:0] owner [CAPACITY];
      logic [WORD_W-1:0] rights [CAPACITY];
      int unsigned       active;
      bit                closing;
      logic [SIZE_W-1:0] size_reg;
      result_type        pending_results [$];
      int                failures;

      function new();
         size_reg = SIZE_W'(64);
         failures = 0;
         clear_slots();
      endfunction

      function void clear_slots();
         for (int i = 0; i < CAPACITY; i++) begin
            in_use[i] = 1'b0;
            generation[i] = GEN_INIT;
            owner[i] = '0;
            rights[i] = '0;
         end
         active = 0;
         closing = 1'b0;
      endfunction

      function int unsigned usable_slots();
         int unsigned n;
         n = size_reg;
         if (n == 0) begin
            n = 1;
         end
         if (n > SIZE_LIMIT) begin
            n = SIZE_LIMIT;
         end
         return n;
      endfunction

      function void write_size(logic [SIZE_W-1:0] value);
         size_reg = value;
         clear_slots();
      endfunction

      function void push_result(status_type st, logic [HANDLE_W-1:0] h, logic [WORD_W-1:0] obj,
                                logic [WORD_W-1:0] granted, logic obj_ok, logic last_flag);
         result_type r;
         r.status = st;
         r.handle_out = h;
         r.object_out = obj;
         r.granted_out = granted;
         r.object_valid = obj_ok;
         r.active_out = SIZE_W'(active);
         r.last = last_flag;
         pending_results.push_back(r);
      endfunction

      function void release_slot(int i);
         in_use[i] = 1'b0;
         owner[i] = '0;
         rights[i] = '0;
         generation[i] = (generation[i] == GEN_MAX) ? '0 : generation[i] + 1'b1;
         if (active > 0) begin
            active--;
         end
      endfunction

      // Slot index named by the handle, or -1 when the handle is malformed or out of range.
      function int slot_of(logic [HANDLE_W-1:0] h);
         logic [WORD_W-1:0] slot;
         slot = h[WORD_W-1:0];
         if (h == '0 || slot == '0 || h[HANDLE_W-1:WORD_W] == '0 || slot > usable_slots()) begin
            return -1;
         end
         return int'(slot) - 1;
      endfunction

      function bit live_match(int idx, logic [HANDLE_W-1:0] h);
         return in_use[idx] && generation[idx] == h[HANDLE_W-1:WORD_W] && owner[idx] != '0;
      endfunction

      function void note_request(func_type f, logic [HANDLE_W-1:0] h, logic [WORD_W-1:0] obj,
                                 logic [WORD_W-1:0] acc);
         int idx;
         int unsigned n;
         int freed;
         logic [WORD_W-1:0] gone;
         n = usable_slots();
         case (f)
            FUNC_OPEN: begin
               if (obj == '0 || acc == '0) begin
                  push_result(ST_BADARG, '0, '0, '0, 1'b0, 1'b1);
               end else if (closing) begin
                  push_result(ST_TERM, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  idx = -1;
                  for (int i = 0; i < n; i++) begin
                     if (idx < 0 && !in_use[i] && generation[i] != '0) begin
                        idx = i;
                     end
                  end
                  if (idx < 0) begin
                     push_result(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                  end else begin
                     in_use[idx] = 1'b1;
                     owner[idx] = obj;
                     rights[idx] = acc;
                     active++;
                     push_result(ST_OK, {generation[idx], WORD_W'(idx + 1)}, '0, '0, 1'b0, 1'b1);
                  end
               end
            end
            FUNC_LOOKUP: begin
               idx = slot_of(h);
               if (idx < 0) begin
                  push_result(ST_BADHANDLE, '0, '0, '0, 1'b0, 1'b1);
               end else if (closing) begin
                  push_result(ST_TERM, '0, '0, '0, 1'b0, 1'b1);
               end else if (!live_match(idx, h)) begin
                  push_result(ST_BADHANDLE, '0, '0, '0, 1'b0, 1'b1);
               end else if ((acc & ~rights[idx]) != '0) begin
                  push_result(ST_DENIED, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  push_result(ST_OK, '0, owner[idx], rights[idx], 1'b1, 1'b1);
               end
            end
            FUNC_CLOSE: begin
               idx = slot_of(h);
               if (idx < 0 || !live_match(idx, h)) begin
                  push_result(ST_BADHANDLE, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  gone = owner[idx];
                  release_slot(idx);
                  push_result(ST_OK, '0, gone, '0, 1'b1, 1'b1);
               end
            end
            default: begin
               closing = 1'b1;
               freed = 0;
               for (int i = 0; i < n; i++) begin
                  if (in_use[i]) begin
                     gone = owner[i];
                     release_slot(i);
                     push_result(ST_OK, '0, gone, '0, 1'b1, 1'b0);
                     freed++;
                  end
               end
               if (freed == 0) begin
                  push_result(ST_OK, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  pending_results[pending_results.size() - 1].last = 1'b1;
               end
            end
         endcase
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected response: status=%0d handle=%h object=%h granted=%h",
                        got.status, got.handle_out, got.object_out, got.granted_out);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.handle_out !== want.handle_out ||
             got.object_out !== want.object_out || got.granted_out !== want.granted_out ||
             got.object_valid !== want.object_valid || got.active_out !== want.active_out ||
             got.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("response mismatch at %0t", $realtime);
               $display("   expected status=%0d handle=%h object=%h granted=%h ov=%b active=%0d last=%b",
                        want.status, want.handle_out, want.object_out, want.granted_out,
                        want.object_valid, want.active_out, want.last);
               $display("   actual   status=%0d handle=%h object=%h granted=%h ov=%b active=%0d last=%b",
                        got.status, got.handle_out, got.object_out, got.granted_out,
                        got.object_valid, got.active_out, got.last);
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;
   int                send_idle_pct;
   int                recv_stall_pct;
   handle_ledger      ledger;

   ght_req_if req_ch ();
   ght_rsp_if rsp_ch ();

   generational_handle_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = status_type'(rsp_ch.status);
         got.handle_out = rsp_ch.handle_out;
         got.object_out = rsp_ch.object_out;
         got.granted_out = rsp_ch.granted_out;
         got.object_valid = rsp_ch.object_valid;
         got.active_out = rsp_ch.active_out;
         got.last = rsp_ch.last;
         ledger.check_result(got);
      end
   end

   // Valid stays high from one request to the next unless an idle gap is drawn.
   task automatic send(func_type f, logic [HANDLE_W-1:0] h, logic [WORD_W-1:0] obj,
                       logic [WORD_W-1:0] acc);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.handle <= h;
      req_ch.object_id <= obj;
      req_ch.access_mask <= acc;
      do @(posedge clock); while (!req_ch.ready);
      ledger.note_request(f, h, obj, acc);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (ledger.pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      ledger.write_size(value);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly handles of live slots, then stale, out-of-range, malformed and random ones.
   function automatic logic [HANDLE_W-1:0] pick_handle();
      int n;
      int s;
      int r;
      int k;
      n = ledger.usable_slots();
      r = $urandom_range(99);
      s = $urandom_range(n - 1);
      if (r < 65) begin
         for (k = 0; k < n; k++) begin
            if (ledger.in_use[(s + k) % n]) begin
               return {ledger.generation[(s + k) % n], WORD_W'((s + k) % n + 1)};
            end
         end
      end
      if (r < 80) begin
         return {ledger.generation[s] - WORD_W'($urandom_range(1)), WORD_W'(s + 1)};
      end
      if (r < 88) begin
         if ($urandom_range(3) == 0) begin
            return {ledger.generation[0], {WORD_W{1'b1}}};
         end
         return {ledger.generation[0], WORD_W'(n + 1 + $urandom_range(200))};
      end
      if (r < 94) begin
         if ($urandom_range(1) == 0) begin
            return {{WORD_W{1'b0}}, WORD_W'(s + 1)};
         end
         return {ledger.generation[s], {WORD_W{1'b0}}};
      end
      return {$urandom, $urandom};
   endfunction

   task automatic random_request();
      int r;
      int c;
      int s;
      logic [HANDLE_W-1:0] h;
      logic [WORD_W-1:0] obj;
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] granted;
      r = $urandom_range(99);
      if (r < 38) begin
         obj = ($urandom_range(9) == 0) ? '0 : $urandom;
         acc = ($urandom_range(9) == 0) ? '0 : $urandom;
         send(FUNC_OPEN, {$urandom, $urandom}, obj, acc);
      end else if (r < 72) begin
         h = pick_handle();
         s = int'(h[WORD_W-1:0]);
         granted = (h[WORD_W-1:0] != '0 && h[WORD_W-1:0] <= ledger.usable_slots()) ?
                   ledger.rights[s - 1] : $urandom;
         c = $urandom_range(99);
         if (c < 50) begin
            acc = granted & $urandom;
         end else if (c < 65) begin
            acc = granted;
         end else if (c < 80) begin
            acc = '0;
         end else begin
            acc = $urandom;
         end
         send(FUNC_LOOKUP, h, $urandom, acc);
      end else if (r < 94) begin
         send(FUNC_CLOSE, pick_handle(), $urandom, $urandom);
      end else begin
         send(func_type'($urandom_range(3)), {$urandom, $urandom}, $urandom, $urandom);
      end
   endtask

   task automatic run_phase(int mode, logic [SIZE_W-1:0] size_value, int count);
      case (mode)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 49;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 49;
         end
         default: begin
            send_idle_pct = 22;
            recv_stall_pct = 22;
         end
      endcase
      write_size(size_value);
      repeat (count) random_request();
      send(FUNC_CLOSE_ALL, {$urandom, $urandom}, $urandom, $urandom);
      drain();
   endtask

   initial begin
      logic [SIZE_W-1:0] sizes [5];
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_OPEN;
      req_ch.handle = '0;
      req_ch.object_id = '0;
      req_ch.access_mask = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      ledger = new();
      sizes[0] = SIZE_W'(64);
      sizes[1] = SIZE_W'(2);
      sizes[2] = SIZE_W'(127);
      sizes[3] = SIZE_W'(0);
      sizes[4] = SIZE_W'($urandom_range(63, 1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass on the reset-sized table.
      send(FUNC_OPEN, '0, '0, 32'h1);
      send(FUNC_OPEN, '0, 32'h5, '0);
      send(FUNC_OPEN, '1, '1, '1);
      send(FUNC_OPEN, '0, 32'h1, 32'h0000_00F0);
      send(FUNC_LOOKUP, '0, '0, '0);
      send(FUNC_LOOKUP, {32'd1, 32'd0}, '0, '0);
      send(FUNC_LOOKUP, {32'd0, 32'd1}, '0, '0);
      send(FUNC_LOOKUP, {32'd1, 32'd65}, '0, '0);
      send(FUNC_LOOKUP, {32'd2, 32'd1}, '0, '0);
      send(FUNC_LOOKUP, {32'd1, 32'd3}, '0, '0);
      send(FUNC_LOOKUP, '1, '0, '0);
      send(FUNC_LOOKUP, {32'd1, 32'd1}, '1, '1);
      send(FUNC_LOOKUP, {32'd1, 32'd2}, '0, 32'h0F);
      send(FUNC_LOOKUP, {32'd1, 32'd2}, '0, 32'h10);
      send(FUNC_LOOKUP, {32'd1, 32'd2}, '0, '0);
      send(FUNC_CLOSE, {32'd1, 32'd1}, '0, '0);
      send(FUNC_CLOSE, {32'd1, 32'd1}, '0, '0);
      send(FUNC_OPEN, '0, 32'h8000_0000, 32'h8000_0000);
      send(FUNC_LOOKUP, {32'd2, 32'd1}, '0, 32'h8000_0000);
      send(FUNC_CLOSE_ALL, '0, '0, '0);
      send(FUNC_OPEN, '0, 32'h7, 32'h7);
      send(FUNC_OPEN, '0, '0, 32'h7);
      send(FUNC_LOOKUP, {32'd2, 32'd1}, '0, '0);
      send(FUNC_LOOKUP, '0, '0, '0);
      send(FUNC_CLOSE, {32'd3, 32'd1}, '0, '0);
      send(FUNC_CLOSE_ALL, '0, '0, '0);
      drain();

      for (int p = 0; p < 5; p++) begin
         run_phase(p % 4, sizes[p], 18);
      end

      if (ledger.failures == 0 && ledger.pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/ght_pkg.sv
hdl/ght_if.sv
hdl/ght_ram.sv
hdl/generational_handle_table.sv
sim/tb.sv
